@@ rtl/pcpfla_pkg.sv @@
// Shared types, status codes and defaults for the per-CPU page free list allocator.
package pcpfla_pkg;

    // Parameter defaults.
    localparam int NUM_CPUS_DEF   = 8;
    localparam int NUM_FRAMES_DEF = 32768;

    // Head value of a list that has never been filled.
    localparam logic [15:0] EMPTY_MARK = 16'hFFFF;

    // Saturation point of a list count.
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // Result status codes.
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OOM = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;

    // Request kinds.
    localparam logic KIND_FREE  = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    // Configuration register indexes.
    localparam logic REG_FIRST_USABLE = 1'b0;
    localparam logic REG_FRAME_LIMIT  = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_RDCPU,
        S_POP,
        S_VREAD,
        S_WALK,
        S_LFIRST,
        S_LDONE,
        S_FIN
    } t_state;

endpackage

@@ rtl/per_cpu_page_free_list_allocator.sv @@
// Per-CPU LIFO page frame free lists linked through a next-frame memory.
//
// Requests arrive on the input channel (i_valid / o_ready) as a kind, a CPU
// index and a frame number; each request yields exactly one result transfer
// on the output channel (o_valid / i_ready) carrying a status and a frame.
// A free reads the CPU table and then presents its result; a local allocate
// reads the table, pops the head and presents; an allocate that finds no
// frames anywhere reads the table and presents. An allocate that steals
// from another CPU walks half of that CPU's list, rounded up, through the link
// memory, one link per cycle, paced by the single registered read port of the
// next-frame memory; taken frames past the granted one join the requester's list.
// The block handles one request at a time; o_ready is high whenever the
// sequencer is idle, so a new request is taken while a result still waits
// in the output register. If the receiver stalls, the finished result of the
// following request is held in the sequencer until the output register frees.
// Reset clears all lists at once through per-entry valid bits on the CPU table;
// the next-frame memory has no reset and needs no clearing pass. The APB port
// holds first_usable_frame at address 0 and frame_limit at address 4. The user
// writes it only while no request is in flight; the block does not check this.
module per_cpu_page_free_list_allocator #(
    parameter int NUM_CPUS   = pcpfla_pkg::NUM_CPUS_DEF,
    parameter int NUM_FRAMES = pcpfla_pkg::NUM_FRAMES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [2:0]  i_cpu,
    input  logic [14:0] i_frame,
    // Result channel.
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [14:0] o_granted_frame,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CPU_W = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int FA_W  = $clog2(NUM_FRAMES);
    localparam logic [20:0] NF_L   = 21'(NUM_FRAMES);
    localparam logic [6:0]  NCPU_L = 7'(NUM_CPUS);

    localparam logic REG_FIRST_USABLE_C = pcpfla_pkg::REG_FIRST_USABLE;
    localparam logic REG_FRAME_LIMIT_C  = pcpfla_pkg::REG_FRAME_LIMIT;

    // Map a link value onto a memory address; links past the end read frame 0.
    function automatic logic [FA_W-1:0] f_laddr(input logic [15:0] f);
        logic [FA_W-1:0] a;
        a = '0;
        if ({5'd0, f} < NF_L) begin
            a = FA_W'(f);
        end
        return a;
    endfunction

    // ---------------------------------------------------------------------
    // Configuration registers.
    // ---------------------------------------------------------------------
    logic [14:0] r_first_usable;
    logic [15:0] r_frame_limit;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_usable <= 15'd0;
            r_frame_limit  <= 16'h8000;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_FIRST_USABLE_C: r_first_usable <= pwdata[14:0];
                REG_FRAME_LIMIT_C:  r_frame_limit  <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_FIRST_USABLE_C: prdata = {17'd0, r_first_usable};
            REG_FRAME_LIMIT_C:  prdata = {16'd0, r_frame_limit};
        endcase
    end

    // ---------------------------------------------------------------------
    // State registers.
    // ---------------------------------------------------------------------
    pcpfla_pkg::t_state r_state, n_state;

    logic             r_kind,     n_kind;
    logic [CPU_W-1:0] r_cpu,      n_cpu;
    logic [14:0]      r_frame,    n_frame;
    logic [CPU_W-1:0] r_vic,      n_vic;
    logic [15:0]      r_head_cpu, n_head_cpu;  // requester's head, kept for a steal
    logic [15:0]      r_first,    n_first;     // frame that will be granted
    logic [15:0]      r_last,     n_last;      // walk position in the victim list
    logic [15:0]      r_rem,      n_rem;       // links still to step over
    logic [15:0]      r_take,     n_take;
    logic [15:0]      r_vcount,   n_vcount;
    logic [1:0]       r_res_st,   n_res_st;
    logic [14:0]      r_res_gr,   n_res_gr;
    logic             r_o_valid,  n_o_valid;
    logic [1:0]       r_o_status, n_o_status;
    logic [14:0]      r_o_grant,  n_o_grant;

    // CPU table: one entry of {head, count} per CPU, with valid bits that
    // reset clears and a non-empty flag per CPU for the steal search.
    logic [31:0]         m_cpu [NUM_CPUS];
    logic [31:0]         r_cm_rdata;
    logic                r_cm_rvld;
    logic [NUM_CPUS-1:0] r_cm_vld;
    logic [NUM_CPUS-1:0] r_ne;

    logic [CPU_W-1:0] cm_raddr;
    logic             cm_we;
    logic [CPU_W-1:0] cm_waddr;
    logic [31:0]      cm_wdata;
    logic [15:0]      cm_head;
    logic [15:0]      cm_cnt;

    // Next-frame link memory.
    logic [15:0]     m_link [NUM_FRAMES];
    logic [15:0]     r_lm_rdata;
    logic [FA_W-1:0] lm_raddr;
    logic            lm_we;
    logic [FA_W-1:0] lm_waddr;
    logic [15:0]     lm_wdata;

    // Steal search and CPU index folding.
    logic [CPU_W-1:0] vic;
    logic             found;
    logic [CPU_W-1:0] cpu_mod;
    logic             in_acc;
    logic             bad;
    logic [15:0]      take;

    assign in_acc  = i_valid && o_ready;
    assign o_ready = (r_state == pcpfla_pkg::S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_status        = r_o_status;
    assign o_granted_frame = r_o_grant;

    assign cm_head = r_cm_rvld ? r_cm_rdata[31:16] : pcpfla_pkg::EMPTY_MARK;
    assign cm_cnt  = r_cm_rvld ? r_cm_rdata[15:0]  : 16'd0;

    assign bad = (r_frame < r_first_usable) || ({1'b0, r_frame} >= r_frame_limit) ||
                 ({6'd0, r_frame} >= NF_L);
    assign take = 16'((17'(cm_cnt) + 17'd1) >> 1);

    // CPU indexes beyond the table fold back by repeated subtraction.
    always_comb begin
        logic [6:0] c;
        c = {4'd0, i_cpu};
        for (int k = 0; k < 8; k++) begin
            if (c >= NCPU_L) begin
                c = c - NCPU_L;
            end
        end
        cpu_mod = CPU_W'(c);
    end

    // Lowest-numbered CPU with a non-empty list.
    always_comb begin
        vic   = '0;
        found = |r_ne;
        for (int k = NUM_CPUS - 1; k >= 0; k--) begin
            if (r_ne[k]) begin
                vic = CPU_W'(k);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Next state.
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pcpfla_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = pcpfla_pkg::S_RDCPU;
                end
            end
            pcpfla_pkg::S_RDCPU: begin
                priority if (r_kind == pcpfla_pkg::KIND_FREE) begin
                    n_state = pcpfla_pkg::S_FIN;
                end else if (cm_cnt != 16'd0) begin
                    n_state = pcpfla_pkg::S_POP;
                end else if (found) begin
                    n_state = pcpfla_pkg::S_VREAD;
                end else begin
                    n_state = pcpfla_pkg::S_FIN;
                end
            end
            pcpfla_pkg::S_POP:   n_state = pcpfla_pkg::S_FIN;
            pcpfla_pkg::S_VREAD: n_state = pcpfla_pkg::S_WALK;
            pcpfla_pkg::S_WALK: begin
                priority if (r_rem != 16'd0) begin
                    n_state = pcpfla_pkg::S_WALK;
                end else if (r_take == 16'd1) begin
                    n_state = pcpfla_pkg::S_FIN;
                end else begin
                    n_state = pcpfla_pkg::S_LFIRST;
                end
            end
            pcpfla_pkg::S_LFIRST: n_state = pcpfla_pkg::S_LDONE;
            pcpfla_pkg::S_LDONE:  n_state = pcpfla_pkg::S_FIN;
            pcpfla_pkg::S_FIN: begin
                if (!r_o_valid || i_ready) begin
                    n_state = pcpfla_pkg::S_IDLE;
                end
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Datapath and memory controls.
    // ---------------------------------------------------------------------
    always_comb begin
        n_kind     = r_kind;
        n_cpu      = r_cpu;
        n_frame    = r_frame;
        n_vic      = r_vic;
        n_head_cpu = r_head_cpu;
        n_first    = r_first;
        n_last     = r_last;
        n_rem      = r_rem;
        n_take     = r_take;
        n_vcount   = r_vcount;
        n_res_st   = r_res_st;
        n_res_gr   = r_res_gr;
        n_o_valid  = r_o_valid && !i_ready;
        n_o_status = r_o_status;
        n_o_grant  = r_o_grant;

        cm_raddr = r_cpu;
        cm_we    = 1'b0;
        cm_waddr = r_cpu;
        cm_wdata = '0;
        lm_raddr = f_laddr(r_first);
        lm_we    = 1'b0;
        lm_waddr = f_laddr({1'b0, r_frame});
        lm_wdata = cm_head;

        unique case (r_state)
            pcpfla_pkg::S_IDLE: begin
                cm_raddr = cpu_mod;
                if (in_acc) begin
                    n_kind  = i_kind;
                    n_cpu   = cpu_mod;
                    n_frame = i_frame;
                end
            end
            pcpfla_pkg::S_RDCPU: begin
                n_res_gr = 15'd0;
                priority if (r_kind == pcpfla_pkg::KIND_FREE) begin
                    if (bad) begin
                        n_res_st = pcpfla_pkg::ST_BAD;
                    end else begin
                        // Push: the old head becomes the new frame's link.
                        n_res_st = pcpfla_pkg::ST_OK;
                        lm_we    = 1'b1;
                        cm_we    = 1'b1;
                        cm_wdata = {1'b0, r_frame,
                                    (cm_cnt == pcpfla_pkg::COUNT_MAX) ? cm_cnt
                                                                      : cm_cnt + 16'd1};
                    end
                end else if (cm_cnt != 16'd0) begin
                    lm_raddr = f_laddr(cm_head);
                    n_first  = cm_head;
                    n_vcount = cm_cnt;
                end else if (found) begin
                    cm_raddr   = vic;
                    n_vic      = vic;
                    n_head_cpu = cm_head;
                end else begin
                    n_res_st = pcpfla_pkg::ST_OOM;
                end
            end
            pcpfla_pkg::S_POP: begin
                cm_we    = 1'b1;
                cm_wdata = {r_lm_rdata, r_vcount - 16'd1};
                n_res_st = pcpfla_pkg::ST_OK;
                n_res_gr = r_first[14:0];
            end
            pcpfla_pkg::S_VREAD: begin
                n_take   = take;
                n_rem    = take - 16'd1;
                n_first  = cm_head;
                n_last   = cm_head;
                n_vcount = cm_cnt;
                lm_raddr = f_laddr(cm_head);
            end
            pcpfla_pkg::S_WALK: begin
                if (r_rem != 16'd0) begin
                    n_last   = r_lm_rdata;
                    n_rem    = r_rem - 16'd1;
                    lm_raddr = f_laddr(r_lm_rdata);
                end else begin
                    // The link after the last taken frame heads the victim list.
                    cm_we    = 1'b1;
                    cm_waddr = r_vic;
                    cm_wdata = {r_lm_rdata, r_vcount - r_take};
                    n_res_st = pcpfla_pkg::ST_OK;
                    n_res_gr = r_first[14:0];
                    if (r_take != 16'd1) begin
                        lm_we    = ({5'd0, r_last} < NF_L);
                        lm_waddr = f_laddr(r_last);
                        lm_wdata = r_head_cpu;
                    end
                end
            end
            pcpfla_pkg::S_LFIRST: begin
                // Issued after the splice write, so a looped list sees it.
                lm_raddr = f_laddr(r_first);
            end
            pcpfla_pkg::S_LDONE: begin
                cm_we    = 1'b1;
                cm_wdata = {r_lm_rdata, r_take - 16'd1};
            end
            pcpfla_pkg::S_FIN: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_st;
                    n_o_grant  = r_res_gr;
                end
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Registers.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pcpfla_pkg::S_IDLE;
            r_o_valid <= 1'b0;
            r_cm_vld  <= '0;
            r_ne      <= '0;
            r_cm_rvld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_cm_rvld <= r_cm_vld[cm_raddr];
            if (cm_we) begin
                r_cm_vld[cm_waddr] <= 1'b1;
                r_ne[cm_waddr]     <= (cm_wdata[15:0] != 16'd0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_cpu      <= n_cpu;
        r_frame    <= n_frame;
        r_vic      <= n_vic;
        r_head_cpu <= n_head_cpu;
        r_first    <= n_first;
        r_last     <= n_last;
        r_rem      <= n_rem;
        r_take     <= n_take;
        r_vcount   <= n_vcount;
        r_res_st   <= n_res_st;
        r_res_gr   <= n_res_gr;
        r_o_status <= n_o_status;
        r_o_grant  <= n_o_grant;
    end

    // CPU table memory.
    always_ff @(posedge i_clk) begin
        r_cm_rdata <= m_cpu[cm_raddr];
        if (cm_we) begin
            m_cpu[cm_waddr] <= cm_wdata;
        end
    end

    // Link memory.
    always_ff @(posedge i_clk) begin
        r_lm_rdata <= m_link[lm_raddr];
        if (lm_we) begin
            m_link[lm_waddr] <= lm_wdata;
        end
    end

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_ready)
        else $error("request accepted while another is in flight");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != pcpfla_pkg::ST_OK) |-> (o_granted_frame == 15'd0))
        else $error("failed request carries a frame");

    a_walk_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcpfla_pkg::S_WALK) && (r_rem != 16'd0) |=>
        (r_state == pcpfla_pkg::S_WALK))
        else $error("list walk left early");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcpfla_pkg::S_IDLE) |-> !lm_we && !cm_we)
        else $error("memory written while idle");

    a_result_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pcpfla_pkg::S_FIN) && (!r_o_valid || i_ready) |=> o_valid)
        else $error("finished result not presented");

endmodule
